### design/assert_macros.svh
// Assertion helpers included by the cell writer unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define OSDTCW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define OSDTCW_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/osdtcw_pkg.sv
package osdtcw_pkg;

    localparam int CELLS   = 512;
    localparam int CELL_W  = $clog2(CELLS);
    localparam int COLUMNS = 30;

    localparam int GLYPH_W = 7;
    localparam int ATTR_W  = 8;

    localparam int IN_DATA_W  = 80;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 24;

    // Request kinds carried in the input tuser.
    localparam logic [2:0] REQ_SET_CURSOR = 3'd0;
    localparam logic [2:0] REQ_PUT_CHAR   = 3'd1;
    localparam logic [2:0] REQ_PUT_ATTR   = 3'd2;
    localparam logic [2:0] REQ_PUT_NUMBER = 3'd3;
    localparam logic [2:0] REQ_CLEAR      = 3'd4;
    localparam logic [2:0] REQ_READ_CELL  = 3'd5;

    localparam logic [GLYPH_W-1:0] GLYPH_BLANK = '0;
    localparam logic [GLYPH_W-1:0] GLYPH_FALLBACK = 7'h7f;
    localparam logic [GLYPH_W-1:0] GLYPH_DIGIT_ZERO = 7'h30;
    localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
    localparam logic [4:0] MAX_DIGITS = 5'd20;

    // floor(v * DIV10_RECIP / 2**DIV10_SHIFT) equals v / 10 for every 32-bit v.
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int DIV10_SHIFT = 35;

    function automatic logic [GLYPH_W-1:0] clamp_code(input logic [7:0] code);
        logic [GLYPH_W-1:0] g;
        if (code[7] || code < FIRST_PRINTABLE)
        begin
            g = GLYPH_FALLBACK;
        end
        else
        begin
            g = code[GLYPH_W-1:0];
        end
        return g;
    endfunction

endpackage

### design/osdtcw_ram.sv
module osdtcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/osd_text_cell_writer_unit.sv
// On-screen-display character buffer: 512 cells, each a 7-bit glyph code
// (0 is blank) and an 8-bit attribute, with a cursor that wraps.
// Requests enter on the s_ channel, the request kind in s_tuser; every
// request gives exactly one result on the m_ channel: the cursor after the
// request and, for a cell read, that cell's glyph and attribute.
// Work per request, from acceptance to the result being offered:
//   set cursor, put character or attribute, unused kinds: none
//   read cell: a registered memory read
//   put number: per digit cell a divide-by-ten multiply, then the write
//   clear: one cell of both memories written per cycle.
// One request is worked on at a time; s_tready is high only while idle.
// The result waits in an output register, so a new request can be taken
// while the receiver stalls; a second result waits in the unit until the
// register is free.
// After reset the unit blanks all 512 cells of both memories, with
// s_tready low, before it takes its first request.
module osd_text_cell_writer_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [5:0] column, [10:6] row_pos, [18:11] char_code, [26:19] attribute,
    // [58:27] number, [63:59] digit_count, [72:64] cell_index, rest zero
    input  logic [osdtcw_pkg::IN_DATA_W-1:0]    s_tdata,
    // [2:0] req_type
    input  logic [osdtcw_pkg::IN_USER_W-1:0]    s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [8:0] cursor_position, [15:9] cell_glyph, [23:16] cell_attribute
    output logic [osdtcw_pkg::OUT_DATA_W-1:0]   m_tdata
);

    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_NUM_DIV,
        ST_NUM_WR,
        ST_CLEAR,
        ST_DONE
    } state_t;

    localparam int CW = osdtcw_pkg::CELL_W;
    localparam int GW = osdtcw_pkg::GLYPH_W;
    localparam int AW = osdtcw_pkg::ATTR_W;

    // Input fields.
    logic [2:0]  req_type;
    logic [5:0]  column;
    logic [4:0]  row_pos;
    logic [7:0]  char_code;
    logic [7:0]  attribute;
    logic [31:0] number;
    logic [4:0]  digit_count;
    logic [8:0]  cell_index;

    assign req_type    = s_tuser[2:0];
    assign column      = s_tdata[5:0];
    assign row_pos     = s_tdata[10:6];
    assign char_code   = s_tdata[18:11];
    assign attribute   = s_tdata[26:19];
    assign number      = s_tdata[58:27];
    assign digit_count = s_tdata[63:59];
    assign cell_index  = s_tdata[72:64];

    state_t          state_reg;
    logic [CW-1:0]   cursor_reg;
    logic [CW-1:0]   sweep_reg;
    logic [CW-1:0]   pos_reg;
    logic [31:0]     num_val_reg;
    logic [28:0]     quot_reg;
    logic [4:0]      num_left_reg;
    logic            num_multi_reg;
    logic [GW-1:0]   res_glyph_reg;
    logic [AW-1:0]   res_attr_reg;
    logic            out_valid_reg;
    logic [osdtcw_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic            accept;
    logic            out_free;
    logic [10:0]     set_sum;
    logic [CW-1:0]   cursor_set_next;
    logic [CW-1:0]   cursor_num_next;
    logic [CW-1:0]   pos_num_next;
    logic [63:0]     div_prod;
    logic [31:0]     ten_quot;
    logic [31:0]     rem_full;
    logic [GW-1:0]   digit_glyph;
    logic [CW-1:0]   addr_read;
    logic            glyph_we;
    logic            attr_we;
    logic [CW-1:0]   wr_addr;
    logic [GW-1:0]   glyph_wdata;
    logic [AW-1:0]   attr_wdata;
    logic [GW-1:0]   glyph_rdata;
    logic [AW-1:0]   attr_rdata;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Cell arithmetic wraps by dropping the bits above the cell index.
    assign set_sum = 11'(column) + 11'(row_pos) * 11'(osdtcw_pkg::COLUMNS);
    assign cursor_set_next = set_sum[CW-1:0];
    assign cursor_num_next = cursor_reg + CW'(digit_count);
    assign pos_num_next    = cursor_num_next - CW'(1);
    assign addr_read       = cell_index[CW-1:0];

    // Divide by ten: the quotient is registered, the remainder follows from it.
    assign div_prod = {32'd0, num_val_reg} * {32'd0, osdtcw_pkg::DIV10_RECIP};
    assign ten_quot = {quot_reg, 3'b000} + 32'({quot_reg, 1'b0});
    assign rem_full = num_val_reg - ten_quot;

    // The most significant cell of a number of two or more cells takes the
    // remaining value masked to four bits rather than a decimal digit.
    always_comb
    begin
        if (num_left_reg == 5'd1 && num_multi_reg)
        begin
            digit_glyph = osdtcw_pkg::GLYPH_DIGIT_ZERO + GW'(num_val_reg[3:0]);
        end
        else
        begin
            digit_glyph = osdtcw_pkg::GLYPH_DIGIT_ZERO + GW'(rem_full[3:0]);
        end
    end

    always_comb
    begin
        glyph_we    = 1'b0;
        attr_we     = 1'b0;
        wr_addr     = cursor_reg;
        glyph_wdata = osdtcw_pkg::clamp_code(char_code);
        attr_wdata  = attribute;
        case (state_reg)
            ST_IDLE:
            begin
                glyph_we = accept && (req_type == osdtcw_pkg::REQ_PUT_CHAR ||
                                      req_type == osdtcw_pkg::REQ_PUT_ATTR);
                attr_we  = accept && (req_type == osdtcw_pkg::REQ_PUT_ATTR);
            end
            ST_NUM_WR:
            begin
                glyph_we    = 1'b1;
                wr_addr     = pos_reg;
                glyph_wdata = digit_glyph;
            end
            ST_INIT, ST_CLEAR:
            begin
                glyph_we    = 1'b1;
                attr_we     = 1'b1;
                wr_addr     = sweep_reg;
                glyph_wdata = osdtcw_pkg::GLYPH_BLANK;
                attr_wdata  = '0;
            end
            default:
            begin
                glyph_we = 1'b0;
            end
        endcase
    end

    osdtcw_ram #(
        .WIDTH (GW),
        .DEPTH (osdtcw_pkg::CELLS)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (glyph_we),
        .waddr (wr_addr),
        .wdata (glyph_wdata),
        .raddr (addr_read),
        .rdata (glyph_rdata)
    );

    osdtcw_ram #(
        .WIDTH (AW),
        .DEPTH (osdtcw_pkg::CELLS)
    ) u_attr_ram (
        .clk   (clk),
        .we    (attr_we),
        .waddr (wr_addr),
        .wdata (attr_wdata),
        .raddr (addr_read),
        .rdata (attr_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cursor_reg    <= '0;
            sweep_reg     <= '0;
            num_left_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_INIT, ST_CLEAR:
                begin
                    sweep_reg <= sweep_reg + CW'(1);
                    if (sweep_reg == CW'(osdtcw_pkg::CELLS - 1))
                    begin
                        state_reg <= (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        res_glyph_reg <= '0;
                        res_attr_reg  <= '0;
                        state_reg     <= ST_DONE;
                        case (req_type)
                            osdtcw_pkg::REQ_SET_CURSOR:
                            begin
                                cursor_reg <= cursor_set_next;
                            end
                            osdtcw_pkg::REQ_PUT_CHAR, osdtcw_pkg::REQ_PUT_ATTR:
                            begin
                                cursor_reg <= cursor_reg + CW'(1);
                            end
                            osdtcw_pkg::REQ_PUT_NUMBER:
                            begin
                                cursor_reg    <= cursor_num_next;
                                pos_reg       <= pos_num_next;
                                num_val_reg   <= number;
                                num_left_reg  <= digit_count;
                                num_multi_reg <= (digit_count != 5'd1);
                                if (digit_count != 5'd0 &&
                                    digit_count <= osdtcw_pkg::MAX_DIGITS)
                                begin
                                    state_reg <= ST_NUM_DIV;
                                end
                            end
                            osdtcw_pkg::REQ_CLEAR:
                            begin
                                sweep_reg <= '0;
                                state_reg <= ST_CLEAR;
                            end
                            osdtcw_pkg::REQ_READ_CELL:
                            begin
                                state_reg <= ST_READ;
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_READ:
                begin
                    res_glyph_reg <= glyph_rdata;
                    res_attr_reg  <= attr_rdata;
                    state_reg     <= ST_DONE;
                end
                ST_NUM_DIV:
                begin
                    quot_reg  <= div_prod[63:osdtcw_pkg::DIV10_SHIFT];
                    state_reg <= ST_NUM_WR;
                end
                ST_NUM_WR:
                begin
                    num_val_reg  <= 32'(quot_reg);
                    pos_reg      <= pos_reg - CW'(1);
                    num_left_reg <= num_left_reg - 5'd1;
                    state_reg    <= (num_left_reg == 5'd1) ? ST_DONE : ST_NUM_DIV;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {res_attr_reg, res_glyph_reg, cursor_reg};
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `OSDTCW_ASSERT(a_done_offers_result,
        (state_reg == ST_DONE && out_free) |=> (m_tvalid && state_reg == ST_IDLE),
        "finished request was not moved to the output register")
    `OSDTCW_ASSERT(a_number_keeps_attr,
        (state_reg == ST_NUM_WR || state_reg == ST_NUM_DIV) |-> (!attr_we && num_left_reg != 5'd0),
        "number write touched attributes or ran past its last cell")
    `OSDTCW_ASSERT_ALWAYS(a_no_request_in_sweep,
        (state_reg == ST_INIT || state_reg == ST_CLEAR) |-> !s_tready,
        "request taken while the memories are being blanked")

endmodule
